[rtl/udec_pkg.sv]
// ----------------------------------------------------------------------------
// udec_pkg
// Shared constants and types for the unsigned to decimal ASCII unit.
// ----------------------------------------------------------------------------
package udec_pkg;

   // Input and output field widths.
   localparam int VALUE_WIDTH = 32;
   localparam int FIELD_WIDTH = 5;
   localparam int CHAR_WIDTH  = 8;
   localparam int POS_WIDTH   = 4;

   // Largest text field and largest digit count of a 32-bit value.
   localparam int MAX_FIELD  = 16;
   localparam int MAX_DIGITS = 10;

   // Bits needed to index the digit array.
   localparam int DIGIT_IDX_WIDTH = $clog2(MAX_DIGITS);

   // Character codes.
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] TERMINATOR = 8'h00;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_EMIT
   } state_type;

   // One packed BCD digit.
   typedef logic [3:0] digit_type;

endpackage

[rtl/unsigned_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii_unit
// Converts a 32-bit unsigned value to ASCII decimal text, one character per
// output transfer, most significant character first.
// ----------------------------------------------------------------------------
// An accepted request first runs shift-and-add-3 binary to BCD conversion
// through one shared digit adjust unit, then sizes the field, then sends
// one character per cycle while rsp_ready is high. A request sends 1 to 16
// characters; a request with zero capacity is taken but sends nothing.
// req_ready is high only while the unit is free; the last character may
// still be waiting in the output register when the next request is taken.
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii_unit
   import udec_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [FIELD_WIDTH-1:0] req_fixed_width,
   input  logic [FIELD_WIDTH-1:0] req_capacity,
   // Response channel.
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_WIDTH-1:0]  rsp_char_byte,
   output logic [POS_WIDTH-1:0]   rsp_position,
   output logic                   rsp_last
);

   localparam logic [FIELD_WIDTH-1:0] MAX_FIELD_W  = FIELD_WIDTH'(MAX_FIELD);
   localparam logic [FIELD_WIDTH-1:0] LAST_STEP    = FIELD_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [FIELD_WIDTH-1:0] MAX_DIGITS_W = FIELD_WIDTH'(MAX_DIGITS);

   // Sequencer and datapath registers.
   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   digit_type              bcd_ff [MAX_DIGITS];
   digit_type              bcd_in [MAX_DIGITS];
   logic [FIELD_WIDTH-1:0] step_ff, step_in;
   logic [FIELD_WIDTH-1:0] width_ff, width_in;
   logic [FIELD_WIDTH-1:0] cap_ff, cap_in;
   logic [FIELD_WIDTH-1:0] total_ff, total_in;
   logic [POS_WIDTH-1:0]   index_ff, index_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic [POS_WIDTH-1:0]   pos_ff, pos_in;
   logic                   last_ff, last_in;

   // Control and helper signals.
   logic                   accept;
   logic                   out_free;
   logic                   load_out;
   logic                   final_char;
   logic                   natural_mode;
   logic [FIELD_WIDTH-1:0] cap_sat;
   logic [FIELD_WIDTH-1:0] digit_count;
   logic [FIELD_WIDTH-1:0] room;
   logic [FIELD_WIDTH-1:0] field_total;
   logic [FIELD_WIDTH-1:0] src;
   digit_type              adjusted [MAX_DIGITS];
   logic [CHAR_WIDTH-1:0]  digit_char;

   // Capacity is clamped to the largest field.
   assign cap_sat = (req_capacity > MAX_FIELD_W) ? MAX_FIELD_W : req_capacity;

   assign natural_mode = (width_ff == '0);
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign final_char   = ({1'b0, index_ff} == (total_ff - FIELD_WIDTH'(1)));

   // Shared adjust unit: add three to every digit of five or more; the convert
   // step then shifts the BCD and binary registers left by one bit.
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         adjusted[d] = (bcd_ff[d] >= 4'd5) ? (bcd_ff[d] + 4'd3) : bcd_ff[d];
      end
   end

   // Number of significant digits, at least one.
   always_comb begin
      digit_count = FIELD_WIDTH'(1);
      for (int d = 1; d < MAX_DIGITS; d++) begin
         if (bcd_ff[d] != '0) begin
            digit_count = FIELD_WIDTH'(d + 1);
         end
      end
   end

   // Characters to send: the clipped width in fixed mode, or the kept
   // digits plus the terminator in natural mode.
   always_comb begin
      room = cap_ff - FIELD_WIDTH'(1);
      if (natural_mode) begin
         field_total = ((digit_count <= room) ? digit_count : room) + FIELD_WIDTH'(1);
      end else begin
         field_total = (width_ff <= cap_ff) ? width_ff : cap_ff;
      end
   end

   // Digit selected for the current position, counted from the low end.
   always_comb begin
      src = total_ff - FIELD_WIDTH'(1) - {1'b0, index_ff};
      if (natural_mode) begin
         src = src - FIELD_WIDTH'(1);
      end
      if (src < MAX_DIGITS_W) begin
         digit_char = ASCII_ZERO + {4'd0, bcd_ff[src[DIGIT_IDX_WIDTH-1:0]]};
      end else begin
         digit_char = ASCII_ZERO;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (cap_sat != '0)) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && final_char) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EMIT: begin
            load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // Datapath next values.
   always_comb begin
      bin_in   = bin_ff;
      step_in  = step_ff;
      width_in = width_ff;
      cap_in   = cap_ff;
      total_in = total_ff;
      index_in = index_ff;
      for (int d = 0; d < MAX_DIGITS; d++) begin
         bcd_in[d] = bcd_ff[d];
      end
      if (accept) begin
         bin_in   = req_value;
         step_in  = '0;
         width_in = req_fixed_width;
         cap_in   = cap_sat;
         index_in = '0;
         for (int d = 0; d < MAX_DIGITS; d++) begin
            bcd_in[d] = '0;
         end
      end else if (state_ff == ST_CONVERT) begin
         bin_in    = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         step_in   = step_ff + FIELD_WIDTH'(1);
         bcd_in[0] = {adjusted[0][2:0], bin_ff[VALUE_WIDTH-1]};
         for (int d = 1; d < MAX_DIGITS; d++) begin
            bcd_in[d] = {adjusted[d][2:0], adjusted[d-1][3]};
         end
      end else if (state_ff == ST_SIZE) begin
         total_in = field_total;
      end else if (load_out) begin
         index_in = index_ff + POS_WIDTH'(1);
      end
   end

   // Output register next values.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         char_in      = (natural_mode && final_char) ? TERMINATOR : digit_char;
         pos_in       = index_ff;
         last_in      = final_char;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      step_ff  <= step_in;
      width_ff <= width_in;
      cap_ff   <= cap_in;
      total_ff <= total_in;
      index_ff <= index_in;
      char_ff  <= char_in;
      pos_ff   <= pos_in;
      last_ff  <= last_in;
      for (int d = 0; d < MAX_DIGITS; d++) begin
         bcd_ff[d] <= bcd_in[d];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_byte = char_ff;
   assign rsp_position  = pos_ff;
   assign rsp_last      = last_ff;

endmodule

[rtl/udec_checker.sv]
// ----------------------------------------------------------------------------
// udec_checker
// Port-level checks for the unsigned to decimal ASCII unit, bound to the top.
// ----------------------------------------------------------------------------
module udec_checker
   import udec_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [CHAR_WIDTH-1:0]  rsp_char_byte,
   input logic [POS_WIDTH-1:0]   rsp_position,
   input logic                   rsp_last
);

   // A stalled response keeps its valid and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_byte)
         && $stable(rsp_position) && $stable(rsp_last))
      else $error("stalled response changed");

   // While characters of a request remain, no new request is taken.
   a_busy_while_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken before the last character");

   // The terminator only ever closes a string.
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char_byte == TERMINATOR) |-> rsp_last)
      else $error("terminator not marked last");

   // Every other character is a decimal digit.
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_char_byte != TERMINATOR) |->
         (rsp_char_byte >= ASCII_ZERO) && (rsp_char_byte <= ASCII_ZERO + 8'd9))
      else $error("character outside the decimal digits");

endmodule

bind unsigned_to_decimal_ascii_unit udec_checker u_udec_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_char_byte (rsp_char_byte),
   .rsp_position  (rsp_position),
   .rsp_last      (rsp_last)
);
